### rtl/core/ordered_value_list_store_defines.svh
// Assertion macros shared by the ordered value list store RTL.
// Included by the files that carry concurrent assertions; needs no package.
`ifndef ORDERED_VALUE_LIST_STORE_DEFINES_SVH
`define ORDERED_VALUE_LIST_STORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define OVLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define OVLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ovls_pkg.sv
// Package for the ordered value list store: command and status codes,
// result record type and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ovls_pkg;

    localparam int KEY_W = 32;
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;
    localparam int POS_W = 5;
    localparam int CNT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND       = 3'd0,
        OP_SEARCH       = 3'd1,
        OP_REMOVE_FIRST = 3'd2,
        OP_REMOVE_ALL   = 3'd3,
        OP_CLEAR        = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [CNT_W-1:0]   removed_count;
        logic [CNT_W-1:0]   entry_count;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/ovls_if.sv
// Valid/ready channel interfaces for the ordered value list store:
// the command channel and the result channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ovls_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] key_value;

    modport source (output valid, output opcode, output key_value, input ready);
    modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

interface ovls_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       found;
    logic [4:0] position;
    logic [5:0] removed_count;
    logic [5:0] entry_count;

    modport source (output valid, output status, output found, output position,
                    output removed_count, output entry_count, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input removed_count, input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/core/ovls_out_reg.sv
// Result output register for the ordered value list store.
// Depends on ovls_pkg (result_t) and ovls_res_if.
`timescale 1ns / 1ps
`default_nettype none

module ovls_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ovls_pkg::result_t load_data,
    output logic                   can_load,
    ovls_res_if.source             res
);

    logic              valid_reg;
    logic              valid_next;
    ovls_pkg::result_t data_reg;

    // Take a new result when empty or when the held one leaves this cycle
    assign can_load = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    // Drive the result channel
    assign res.valid         = valid_reg;
    assign res.status        = data_reg.status;
    assign res.found         = data_reg.found;
    assign res.position      = data_reg.position;
    assign res.removed_count = data_reg.removed_count;
    assign res.entry_count   = data_reg.entry_count;

endmodule

`default_nettype wire

### rtl/core/ordered_value_list_store.sv
// Ordered value list store: keeps up to DEPTH 32-bit values in insertion order
// in one synchronous memory with a registered read. Append, clear and unused
// opcodes go from acceptance straight to the result state. Search and both removes
// scan the held entries one memory read per cycle, compacting in place through
// the same memory's write port; a search stops at its first match. One command
// is worked at a time; a new command is taken while a finished result still
// waits in the output register. No clearing pass after reset: only entries
// below the count are read.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_value_list_store_defines.svh"

module ordered_value_list_store #(
    parameter int DEPTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ovls_cmd_if.sink   cmd,
    ovls_res_if.source res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ovls_pkg::POS_W;
    localparam int NW = ovls_pkg::CNT_W;
    localparam int KW = ovls_pkg::KEY_W;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        RESULT
    } state_t;

    state_t            state_reg, state_next;
    ovls_pkg::op_t     op_reg, op_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic [CW-1:0]     w_reg, w_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     pos_reg, pos_next;
    ovls_pkg::result_t res_reg, res_next;

    logic [KW-1:0]     mem [DEPTH];
    logic [KW-1:0]     rdata_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [KW-1:0]     wr_data;

    logic              load;
    logic              can_load;
    logic              match;
    logic [CW-1:0]     new_cnt;

    assign cmd.ready = (state_reg == IDLE);
    assign match     = (rdata_reg == key_reg);

    // Command decode, scan and compaction
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        w_next        = w_reg;
        hit_next      = hit_reg;
        pos_next      = pos_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_idx_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = w_reg[AW-1:0];
        wr_data       = rdata_reg;
        load          = 1'b0;
        new_cnt       = (op_reg == ovls_pkg::OP_SEARCH) ? cnt_reg : w_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next  = ovls_pkg::op_t'(cmd.opcode);
                    key_next = cmd.key_value;
                    res_next.status        = ovls_pkg::ST_OK;
                    res_next.found         = 1'b0;
                    res_next.position      = '0;
                    res_next.removed_count = '0;
                    res_next.entry_count   = NW'(cnt_reg);
                    state_next = RESULT;
                    unique case (ovls_pkg::op_t'(cmd.opcode)) inside
                        ovls_pkg::OP_APPEND:
                        begin
                            if (cnt_reg == CW'(DEPTH))
                            begin
                                res_next.status = ovls_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = cnt_reg[AW-1:0];
                                wr_data  = cmd.key_value;
                                cnt_next = CW'(cnt_reg + 1'b1);
                                res_next.entry_count = NW'(cnt_reg + 1'b1);
                            end
                        end
                        ovls_pkg::OP_SEARCH, ovls_pkg::OP_REMOVE_FIRST,
                        ovls_pkg::OP_REMOVE_ALL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ovls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next  = SCAN;
                                rd_idx_next = '0;
                                w_next      = '0;
                                hit_next    = 1'b0;
                                pos_next    = '0;
                            end
                        end
                        ovls_pkg::OP_CLEAR:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ovls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                res_next.removed_count = NW'(cnt_reg);
                                res_next.entry_count   = '0;
                                cnt_next               = '0;
                            end
                        end
                        default:
                        begin
                            // unused opcode: report the count, change nothing
                        end
                    endcase
                end
            end

            SCAN:
            begin
                if ((!pend_reg && rd_idx_reg == cnt_reg) ||
                    (op_reg == ovls_pkg::OP_SEARCH && hit_reg))
                begin
                    // Finish: drop any read still in flight
                    res_next.status        = hit_reg ? ovls_pkg::ST_OK
                                                     : ovls_pkg::ST_NOT_FOUND;
                    res_next.found         = hit_reg;
                    res_next.position      = PW'(pos_reg);
                    res_next.removed_count = NW'(cnt_reg - new_cnt);
                    res_next.entry_count   = NW'(new_cnt);
                    cnt_next               = new_cnt;
                    state_next             = RESULT;
                end
                else
                begin
                    // Issue the next read
                    if (rd_idx_reg < cnt_reg)
                    begin
                        rd_en         = 1'b1;
                        rd_idx_next   = CW'(rd_idx_reg + 1'b1);
                        pend_next     = 1'b1;
                        pend_idx_next = rd_idx_reg[AW-1:0];
                    end
                    // Examine the entry read last cycle
                    if (pend_reg)
                    begin
                        if (!hit_reg)
                        begin
                            if (match)
                            begin
                                hit_next = 1'b1;
                                pos_next = pend_idx_reg;
                            end
                            else
                            begin
                                w_next = CW'(w_reg + 1'b1);
                            end
                        end
                        else if (op_reg == ovls_pkg::OP_REMOVE_ALL && match)
                        begin
                            // drop another match
                        end
                        else if (op_reg != ovls_pkg::OP_SEARCH)
                        begin
                            // Move the kept entry down over the gap
                            wr_en  = 1'b1;
                            w_next = CW'(w_reg + 1'b1);
                        end
                    end
                end
            end

            RESULT:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold state and registered control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            w_reg      <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            w_reg      <= w_next;
            hit_reg    <= hit_next;
        end
    end

    // Hold the command payload and result
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        res_reg      <= res_next;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    ovls_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (res_reg),
        .can_load  (can_load),
        .res       (res)
    );

    `OVLS_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(DEPTH), "count above depth")
    `OVLS_ASSERT_NOW(a_wr_behind_rd, clk, rst_n, (state_reg == SCAN) && wr_en, pend_reg && (w_reg < CW'(pend_idx_reg)), "compaction write not behind scan")
    `OVLS_ASSERT_NOW(a_rd_in_list, clk, rst_n, state_reg == SCAN, rd_idx_reg <= cnt_reg, "scan read past list end")
    `OVLS_ASSERT_NEXT(a_accept_busy, clk, rst_n, cmd.valid && cmd.ready, state_reg != IDLE, "accepted transaction left no work")

endmodule

`default_nettype wire
